/* rtl/core/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* rtl/core/hptm_pkg.sv */
`timescale 1ns / 1ps

package hptm_pkg;

    localparam int DATA_W             = 16;
    localparam int GAIN_W             = 16;
    localparam int DT_W               = 16;
    localparam int MODE_W             = 2;
    localparam int DIFF_W             = DATA_W + 1;
    localparam int DIV_W              = 32;
    localparam int INTEGRAL_WIDTH_DEF = 32;
    localparam int ACC_GUARD          = 18;
    localparam int RND_W              = 23;
    localparam int RND_SHIFT          = 7;
    localparam int ONE_Q14            = 16384;
    localparam int ONE_Q21            = 2097152;
    localparam int CFG_IDX_W          = 2;

    localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TELEOP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HOLD   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DRIVE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 2'd2;

    localparam logic signed [GAIN_W-1:0] GAIN_P_RST = 16'sd256;
    localparam logic signed [GAIN_W-1:0] GAIN_I_RST = 16'sd0;
    localparam logic signed [GAIN_W-1:0] GAIN_D_RST = 16'sd0;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] yaw_error;
        logic [DT_W-1:0]          elapsed_ms;
        logic signed [DATA_W-1:0] surge_effort;
        logic signed [DATA_W-1:0] teleop_thrust;
        logic signed [DATA_W-1:0] teleop_turn;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] motor_left;
        logic signed [DATA_W-1:0] motor_right;
        logic signed [DATA_W-1:0] turn_signal;
    } out_t;

    typedef struct packed {
        logic start;
        logic load;
    } mac_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DMUL,
        ST_DIV,
        ST_PMUL,
        ST_IMUL,
        ST_RND,
        ST_FIN
    } state_t;

endpackage

/* rtl/core/hptm_mac.sv */
`timescale 1ns / 1ps

module hptm_mac #(
    parameter int ACC_W = hptm_pkg::INTEGRAL_WIDTH_DEF + hptm_pkg::ACC_GUARD
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  hptm_pkg::mac_ctl_t                 ctl,
    input  logic signed [ACC_W-1:0]            mcand,
    input  logic signed [hptm_pkg::GAIN_W-1:0] gain,
    input  logic signed [ACC_W-1:0]            load_value,
    output logic signed [ACC_W-1:0]            acc,
    output logic                               done
);
    import hptm_pkg::*;

    localparam int CNT_W = $clog2(GAIN_W);

    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] mcand_reg, mcand_next;
    logic [GAIN_W-1:0]       mplier_reg, mplier_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic signed [ACC_W-1:0] addend;
    logic signed [ACC_W-1:0] step_sum;
    logic                    last;

    assign addend   = mplier_reg[0] ? mcand_reg : '0;
    assign last     = (cnt_reg == CNT_W'(GAIN_W - 1));
    assign step_sum = last ? (acc_reg - addend) : (acc_reg + addend);

    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (ctl.start)
        begin
            if (ctl.load)
            begin
                acc_next = load_value;
            end
            mcand_next  = mcand;
            mplier_next = gain;
            cnt_next    = '0;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next    = step_sum;
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

/* rtl/core/hptm_div.sv */
`timescale 1ns / 1ps

module hptm_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [hptm_pkg::DIV_W-1:0]    dividend,
    input  logic [hptm_pkg::DT_W-1:0]     divisor,
    output logic [hptm_pkg::DIV_W-1:0]    quotient,
    output logic                          done
);
    import hptm_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic [DIV_W-1:0] dvd_reg, dvd_next;
    logic [DT_W-1:0]  rem_reg, rem_next;
    logic [DT_W-1:0]  dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DT_W:0]    shifted;
    logic [DT_W:0]    trial;
    logic             fits;

    assign shifted = {rem_reg, dvd_reg[DIV_W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};
    assign fits    = (shifted >= {1'b0, dsr_reg});

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[DT_W-1:0] : shifted[DT_W-1:0];
            dvd_next = {dvd_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = dvd_reg;
    assign done     = done_reg;

endmodule

/* rtl/core/hptm_mixer.sv */
`timescale 1ns / 1ps

module hptm_mixer (
    input  logic signed [hptm_pkg::DATA_W-1:0] effort,
    input  logic signed [hptm_pkg::DATA_W-1:0] turn,
    output logic signed [hptm_pkg::DATA_W-1:0] left,
    output logic signed [hptm_pkg::DATA_W-1:0] right
);
    import hptm_pkg::*;

    localparam int MIX_W = DATA_W + 2;
    localparam logic signed [MIX_W-1:0] ONE    = MIX_W'(ONE_Q14);
    localparam logic signed [MIX_W:0]   ONE_X  = (MIX_W + 1)'(ONE_Q14);
    localparam logic signed [DATA_W-1:0] SAT_HI = DATA_W'(ONE_Q14);
    localparam logic signed [DATA_W-1:0] SAT_LO = DATA_W'(-ONE_Q14);

    logic signed [MIX_W-1:0] m0, m1, ov0, ov1, mag0, mag1, adj0, adj1;
    logic signed [MIX_W:0]   d0, d1;

    function automatic logic signed [MIX_W-1:0] overage(input logic signed [MIX_W-1:0] m);
        logic signed [MIX_W-1:0] r;
        begin
            if (m > ONE)
            begin
                r = m - ONE;
            end
            else if (m < -ONE)
            begin
                r = m + ONE;
            end
            else
            begin
                r = '0;
            end
            return r;
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] sat(input logic signed [MIX_W:0] v);
        logic signed [DATA_W-1:0] r;
        begin
            if (v > ONE_X)
            begin
                r = SAT_HI;
            end
            else if (v < -ONE_X)
            begin
                r = SAT_LO;
            end
            else
            begin
                r = v[DATA_W-1:0];
            end
            return r;
        end
    endfunction

    always_comb
    begin
        m0   = MIX_W'(effort) - MIX_W'(turn);
        m1   = MIX_W'(effort) + MIX_W'(turn);
        ov0  = overage(m0);
        ov1  = overage(m1);
        mag0 = ov0[MIX_W-1] ? -ov0 : ov0;
        mag1 = ov1[MIX_W-1] ? -ov1 : ov1;
        if (mag0 < mag1)
        begin
            adj0 = m0[MIX_W-1] ? -mag1 : mag1;
            adj1 = ov1;
        end
        else
        begin
            adj0 = ov0;
            adj1 = m1[MIX_W-1] ? -mag0 : mag0;
        end
        d0    = (MIX_W + 1)'(m0) - (MIX_W + 1)'(adj0);
        d1    = (MIX_W + 1)'(m1) - (MIX_W + 1)'(adj1);
        left  = sat(d0);
        right = sat(d1);
    end

endmodule

/* rtl/core/heading_pid_thrust_mixer.sv */
// An accepted item steps through START, then in drive mode with nonzero elapsed time DMUL,
// DIV, PMUL and IMUL, in drive mode with zero elapsed time PMUL and IMUL, then RND and FIN.
// A new item is taken only in IDLE, after FIN has handed the result on; the serial multiplier
// (run for derivative, proportional and integral gain) and the serial divider set the pace.
// Reset: asynchronous, clears gains to their defaults, previous error and integral to 0.
`timescale 1ns / 1ps

module heading_pid_thrust_mixer #(
    parameter int INTEGRAL_WIDTH = hptm_pkg::INTEGRAL_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  hptm_pkg::in_t                    in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output hptm_pkg::out_t                   out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hptm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hptm_pkg::DATA_W-1:0]      cfg_data
);
    import hptm_pkg::*;

    localparam int ACC_W = INTEGRAL_WIDTH + ACC_GUARD;
    localparam logic signed [ACC_W-1:0] CLIP_HI = ACC_W'(ONE_Q21);
    localparam logic signed [ACC_W-1:0] CLIP_LO = -CLIP_HI;
    localparam logic signed [INTEGRAL_WIDTH-1:0] INT_MAX = {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
    localparam logic signed [INTEGRAL_WIDTH-1:0] INT_MIN = {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};

    state_t state_reg, state_next;

    logic signed [GAIN_W-1:0]         gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [DATA_W-1:0]         prev_err_reg, prev_err_next;
    logic signed [INTEGRAL_WIDTH-1:0] integ_reg, integ_next;
    in_t                              item_reg, item_next;
    logic signed [DIFF_W-1:0]         diff_reg, diff_next;
    logic signed [DATA_W-1:0]         turn_reg, turn_next;
    logic signed [DATA_W-1:0]         effort_reg, effort_next;
    out_t                             out_reg, out_next;
    logic                             out_valid_reg, out_valid_next;

    logic                             in_xfer;
    logic signed [INTEGRAL_WIDTH:0]   integ_sum;
    logic signed [INTEGRAL_WIDTH-1:0] integ_sat;

    mac_ctl_t                         mac_ctl;
    logic signed [ACC_W-1:0]          mac_mcand;
    logic signed [GAIN_W-1:0]         mac_gain;
    logic signed [ACC_W-1:0]          mac_load;
    logic signed [ACC_W-1:0]          mac_acc;
    logic                             mac_done;

    logic                             div_start;
    logic [DIV_W-1:0]                 div_quo;
    logic                             div_done;
    logic                             prod_neg;
    logic [ACC_W-1:0]                 prod_mag;
    logic signed [ACC_W-1:0]          quo_ext;

    logic signed [ACC_W-1:0]          clipped;
    logic [RND_W-1:0]                 rnd_sum;
    logic signed [DATA_W-1:0]         turn_rnd;
    logic signed [DATA_W-1:0]         mix_left, mix_right;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= GAIN_P_RST;
            gain_i_reg <= GAIN_I_RST;
            gain_d_reg <= GAIN_D_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GAIN_P: gain_p_reg <= cfg_data;
                CFG_GAIN_I: gain_i_reg <= cfg_data;
                CFG_GAIN_D: gain_d_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign integ_sum = (INTEGRAL_WIDTH + 1)'(integ_reg)
                     + (INTEGRAL_WIDTH + 1)'(in_data.yaw_error);
    assign integ_sat = (integ_sum[INTEGRAL_WIDTH] != integ_sum[INTEGRAL_WIDTH-1])
                     ? (integ_sum[INTEGRAL_WIDTH] ? INT_MIN : INT_MAX)
                     : integ_sum[INTEGRAL_WIDTH-1:0];

    always_comb
    begin
        item_next     = item_reg;
        diff_next     = diff_reg;
        prev_err_next = prev_err_reg;
        integ_next    = integ_reg;
        if (in_xfer)
        begin
            item_next = in_data;
            if (in_data.mode == MODE_DRIVE)
            begin
                diff_next     = DIFF_W'(in_data.yaw_error) - DIFF_W'(prev_err_reg);
                prev_err_next = in_data.yaw_error;
                if ((in_data.elapsed_ms != '0) && (gain_i_reg != '0))
                begin
                    integ_next = integ_sat;
                end
            end
            else
            begin
                integ_next = '0;
            end
        end
    end

    assign prod_neg = mac_acc[ACC_W-1];
    assign prod_mag = prod_neg ? (-mac_acc) : mac_acc;
    assign quo_ext  = {{(ACC_W - DIV_W){1'b0}}, div_quo};

    assign clipped  = (mac_acc > CLIP_HI) ? CLIP_HI : ((mac_acc < CLIP_LO) ? CLIP_LO : mac_acc);
    assign rnd_sum  = clipped[RND_W-1:0] + RND_W'(1 << (RND_SHIFT - 1));
    assign turn_rnd = rnd_sum[RND_W-1:RND_SHIFT];

    always_comb
    begin
        state_next     = state_reg;
        mac_ctl        = '0;
        mac_mcand      = ACC_W'(item_reg.yaw_error);
        mac_gain       = gain_p_reg;
        mac_load       = '0;
        div_start      = 1'b0;
        turn_next      = turn_reg;
        effort_next    = effort_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (item_reg.mode == MODE_DRIVE)
                begin
                    mac_ctl.start = 1'b1;
                    mac_ctl.load  = 1'b1;
                    if (item_reg.elapsed_ms != '0)
                    begin
                        mac_mcand  = ACC_W'(diff_reg);
                        mac_gain   = gain_d_reg;
                        state_next = ST_DMUL;
                    end
                    else
                    begin
                        state_next = ST_PMUL;
                    end
                end
                else
                begin
                    state_next = ST_RND;
                end
            end
            ST_DMUL:
            begin
                if (mac_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    mac_ctl.start = 1'b1;
                    mac_ctl.load  = 1'b1;
                    mac_load      = prod_neg ? -quo_ext : quo_ext;
                    state_next    = ST_PMUL;
                end
            end
            ST_PMUL:
            begin
                if (mac_done)
                begin
                    mac_ctl.start = 1'b1;
                    mac_mcand     = ACC_W'(integ_reg);
                    mac_gain      = gain_i_reg;
                    state_next    = ST_IMUL;
                end
            end
            ST_IMUL:
            begin
                if (mac_done)
                begin
                    state_next = ST_RND;
                end
            end
            ST_RND:
            begin
                case (item_reg.mode)
                    MODE_DRIVE:
                    begin
                        turn_next   = turn_rnd;
                        effort_next = item_reg.surge_effort;
                    end
                    MODE_TELEOP:
                    begin
                        turn_next   = item_reg.teleop_turn;
                        effort_next = item_reg.teleop_thrust;
                    end
                    default:
                    begin
                        turn_next   = '0;
                        effort_next = '0;
                    end
                endcase
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.motor_left  = mix_left;
                    out_next.motor_right = mix_right;
                    out_next.turn_signal = turn_reg;
                    out_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            prev_err_reg  <= '0;
            integ_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            prev_err_reg  <= prev_err_next;
            integ_reg     <= integ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        diff_reg   <= diff_next;
        turn_reg   <= turn_next;
        effort_reg <= effort_next;
        out_reg    <= out_next;
    end

    hptm_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (mac_ctl),
        .mcand      (mac_mcand),
        .gain       (mac_gain),
        .load_value (mac_load),
        .acc        (mac_acc),
        .done       (mac_done)
    );

    hptm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_mag[DIV_W-1:0]),
        .divisor  (item_reg.elapsed_ms),
        .quotient (div_quo),
        .done     (div_done)
    );

    hptm_mixer u_mixer (
        .effort (effort_reg),
        .turn   (turn_reg),
        .left   (mix_left),
        .right  (mix_right)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* rtl/core/hptm_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hptm_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input hptm_pkg::out_t out_data
);
    import hptm_pkg::*;

    logic motors_in_range;

    assign motors_in_range = (out_data.motor_left <= ONE_Q14)
                          && (out_data.motor_left >= -ONE_Q14)
                          && (out_data.motor_right <= ONE_Q14)
                          && (out_data.motor_right >= -ONE_Q14);

    // hold a stalled result
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

    // motors stay within full scale
    `ASSERT_IMPLIES(a_motor_range, clk, rst_n, out_valid, motors_in_range)

    // one item in flight at a time
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // a new result appears only as the sequencer returns to idle
    `ASSERT_IMPLIES(a_result_at_idle, clk, rst_n, $rose(out_valid), in_ready)

endmodule

bind heading_pid_thrust_mixer hptm_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
